// ===== rtl/ismc_pkg.sv =====
// types and constants for the picture screening and mean color block
// no dependencies; imported by image_screen_mean_color_top
package ismc_pkg;

   localparam int LEVEL_W  = 8;
   localparam int SIDE_W   = 14;
   localparam int BYTES_W  = 32;
   localparam int ASPECT_W = 16;
   localparam int SUM_W    = 35;
   localparam int FRAC_W   = 8;
   localparam int RGB_W    = 24;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam int MAX_SIDE_DEFAULT = 8192;

   localparam logic [BYTES_W-1:0]  MIN_FILE_RESET = '0;
   localparam logic [ASPECT_W-1:0] MAX_ASPECT_RESET = 16'd512;
   localparam logic [SIDE_W-1:0]   MIN_SIDE_RESET = '0;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_FILE   = 2'd0,
      CSR_MAX_ASPECT = 2'd1,
      CSR_MIN_HEIGHT = 2'd2,
      CSR_MIN_WIDTH  = 2'd3
   } csr_index_type;

   // screening verdicts
   typedef enum logic [1:0] {
      ST_PROCESSED  = 2'd0,
      ST_FILE_SMALL = 2'd1,
      ST_ASPECT     = 2'd2,
      ST_TOO_SMALL  = 2'd3
   } status_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] red_level;
      logic [LEVEL_W-1:0] green_level;
      logic [LEVEL_W-1:0] blue_level;
      logic [SIDE_W-1:0]  image_width;
      logic [SIDE_W-1:0]  image_height;
      logic [BYTES_W-1:0] file_bytes;
      logic               last_pixel;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [RGB_W-1:0]   mean_rgb;
      logic [SIDE_W-1:0]  out_width;
      logic [SIDE_W-1:0]  out_height;
   } rsp_type;

endpackage

// ===== rtl/image_screen_mean_color_top.sv =====
// picture screening and mean color block, top level
// depends on ismc_pkg for payload types, register indexes and constants
//
// Usage: pixels stream in on the req_ channel, one transfer per pixel, each
// carrying its red, green and blue levels and the picture's sides and file
// size. A pixel without last_pixel produces nothing; the block keeps three
// saturating channel sums. On the pixel marked last the block drops
// req_ready and screens the picture: three passes through one shared 16x14
// multiplier give both side ratio products and the pixel count, then, for a
// picture that passes, one restoring divider computes the three channel
// means one quotient bit per cycle; a rejected picture skips the divider.
// The result sits in an output register; while it waits for rsp_ready the
// block keeps accepting pixels of the next picture, and only the result of
// a following picture waits for the register to empty, with req_ready low.
// The csr_ channel writes the four screening registers at any time it is
// valid and is always ready; the user must write them only while the block
// is idle, which the block itself does not enforce. Synchronous reset clears
// the sums, returns the sequencer to accumulation, drops rsp_valid and loads
// the register reset values.
module image_screen_mean_color_top
   import ismc_pkg::*;
#(
   parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CMP_W   = 17;
   localparam int MUL_W   = ASPECT_W + SIDE_W;
   localparam int COUNT_W = 2 * SIDE_W;
   localparam int BIT_W   = $clog2(SUM_W);
   localparam logic [SUM_W-1:0] SUM_MAX = '1;
   localparam logic [LEVEL_W-1:0] MEAN_MAX = '1;

   typedef enum logic [5:0] {
      S_ACCUM = 6'b000001,
      S_MUL_H = 6'b000010,
      S_MUL_W = 6'b000100,
      S_MUL_C = 6'b001000,
      S_DIV   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [BYTES_W-1:0]  min_file_ff;
   logic [ASPECT_W-1:0] max_aspect_ff;
   logic [SIDE_W-1:0]   min_height_ff;
   logic [SIDE_W-1:0]   min_width_ff;

   logic [SUM_W-1:0] red_sum_ff, red_sum_in;
   logic [SUM_W-1:0] green_sum_ff, green_sum_in;
   logic [SUM_W-1:0] blue_sum_ff, blue_sum_in;

   logic [SIDE_W-1:0]  width_ff, width_in;
   logic [SIDE_W-1:0]  height_ff, height_in;
   logic               file_small_ff, file_small_in;
   logic               ratio_bad_ff, ratio_bad_in;
   status_type         status_ff, status_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]   div_ff, div_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;
   logic [1:0]         chan_ff, chan_in;
   logic [LEVEL_W-1:0] mean_ff [3];
   logic [LEVEL_W-1:0] mean_in [3];

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                req_xfer;
   logic                out_free;
   logic [SIDE_W-1:0]   width_clamp, height_clamp;
   logic [ASPECT_W-1:0] mul_a;
   logic [SIDE_W-1:0]   mul_b;
   logic [MUL_W-1:0]    mul_p;
   logic [COUNT_W:0]    div_shift;
   logic [COUNT_W+1:0]  div_diff;
   logic                q_bit;
   logic [SUM_W-1:0]    quo_next;
   logic [LEVEL_W-1:0]  mean_now;

   // saturating channel sum
   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
                                                input logic [LEVEL_W-1:0] level);
      logic [SUM_W:0] wide;
      wide = {1'b0, sum} + {{(SUM_W+1-LEVEL_W){1'b0}}, level};
      return wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
   endfunction

   assign req_xfer  = req_valid && req_ready;
   assign req_ready = (state_ff == S_ACCUM);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sides above the limit count as the limit
   assign width_clamp = ({{(CMP_W-SIDE_W){1'b0}}, req_data.image_width} > CMP_W'(MAX_SIDE)) ?
                        SIDE_W'(MAX_SIDE) : req_data.image_width;
   assign height_clamp = ({{(CMP_W-SIDE_W){1'b0}}, req_data.image_height} > CMP_W'(MAX_SIDE)) ?
                         SIDE_W'(MAX_SIDE) : req_data.image_height;

   // shared multiplier operand select
   always_comb begin
      mul_a = max_aspect_ff;
      mul_b = height_ff;
      case (state_ff)
         S_MUL_W: begin
            mul_b = width_ff;
         end
         S_MUL_C: begin
            mul_a = {{(ASPECT_W-SIDE_W){1'b0}}, width_ff};
         end
         default: begin
            mul_b = height_ff;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // restoring divider step, one quotient bit
   assign div_shift = {rem_ff, div_ff[SUM_W-1]};
   assign div_diff  = {1'b0, div_shift} - {2'b0, count_ff};
   assign q_bit     = !div_diff[COUNT_W+1];
   assign quo_next  = {quo_ff[SUM_W-2:0], q_bit};
   assign mean_now  = (count_ff == '0) ? '0 :
                      (|quo_next[SUM_W-1:LEVEL_W]) ? MEAN_MAX : quo_next[LEVEL_W-1:0];

   // sequencer and datapath next state
   always_comb begin
      state_in      = state_ff;
      red_sum_in    = red_sum_ff;
      green_sum_in  = green_sum_ff;
      blue_sum_in   = blue_sum_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      file_small_in = file_small_ff;
      ratio_bad_in  = ratio_bad_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      bit_in        = bit_ff;
      chan_in       = chan_ff;
      mean_in       = mean_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         S_ACCUM: begin
            if (req_xfer) begin
               red_sum_in   = sat_add(red_sum_ff, req_data.red_level);
               green_sum_in = sat_add(green_sum_ff, req_data.green_level);
               blue_sum_in  = sat_add(blue_sum_ff, req_data.blue_level);
               if (req_data.last_pixel) begin
                  width_in      = width_clamp;
                  height_in     = height_clamp;
                  file_small_in = (req_data.file_bytes < min_file_ff);
                  state_in      = S_MUL_H;
               end
            end
         end
         S_MUL_H: begin
            // width too wide against height
            ratio_bad_in = ({{(MUL_W-SIDE_W-FRAC_W){1'b0}}, width_ff, {FRAC_W{1'b0}}} > mul_p);
            state_in     = S_MUL_W;
         end
         S_MUL_W: begin
            // height too tall against width
            ratio_bad_in = ratio_bad_ff ||
                           ({{(MUL_W-SIDE_W-FRAC_W){1'b0}}, height_ff, {FRAC_W{1'b0}}} > mul_p);
            state_in     = S_MUL_C;
         end
         S_MUL_C: begin
            count_in = mul_p[COUNT_W-1:0];
            mean_in  = '{default: '0};
            if (file_small_ff) begin
               status_in = ST_FILE_SMALL;
            end else if (ratio_bad_ff) begin
               status_in = ST_ASPECT;
            end else if (height_ff < min_height_ff || width_ff < min_width_ff) begin
               status_in = ST_TOO_SMALL;
            end else begin
               status_in = ST_PROCESSED;
            end
            if (file_small_ff || ratio_bad_ff ||
                height_ff < min_height_ff || width_ff < min_width_ff) begin
               state_in = S_DONE;
            end else begin
               div_in   = red_sum_ff;
               rem_in   = '0;
               quo_in   = '0;
               bit_in   = '0;
               chan_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = q_bit ? div_diff[COUNT_W-1:0] : div_shift[COUNT_W-1:0];
            quo_in = quo_next;
            div_in = {div_ff[SUM_W-2:0], 1'b0};
            bit_in = bit_ff + 1'b1;
            if (bit_ff == BIT_W'(SUM_W-1)) begin
               mean_in[chan_ff] = mean_now;
               rem_in  = '0;
               quo_in  = '0;
               bit_in  = '0;
               chan_in = chan_ff + 1'b1;
               if (chan_ff == 2'd0) begin
                  div_in = green_sum_ff;
               end else if (chan_ff == 2'd1) begin
                  div_in = blue_sum_ff;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.status = status_ff;
               if (status_ff == ST_PROCESSED) begin
                  rsp_data_in.mean_rgb   = {mean_ff[0], mean_ff[1], mean_ff[2]};
                  rsp_data_in.out_width  = width_ff;
                  rsp_data_in.out_height = height_ff;
               end else begin
                  rsp_data_in.mean_rgb   = '0;
                  rsp_data_in.out_width  = '0;
                  rsp_data_in.out_height = '0;
               end
               red_sum_in   = '0;
               green_sum_in = '0;
               blue_sum_in  = '0;
               state_in     = S_ACCUM;
            end
         end
         default: begin
            state_in = S_ACCUM;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ACCUM;
         rsp_valid_ff <= 1'b0;
         red_sum_ff   <= '0;
         green_sum_ff <= '0;
         blue_sum_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         red_sum_ff   <= red_sum_in;
         green_sum_ff <= green_sum_in;
         blue_sum_ff  <= blue_sum_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      width_ff      <= width_in;
      height_ff     <= height_in;
      file_small_ff <= file_small_in;
      ratio_bad_ff  <= ratio_bad_in;
      status_ff     <= status_in;
      count_ff      <= count_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      bit_ff        <= bit_in;
      chan_ff       <= chan_in;
      mean_ff       <= mean_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // screening registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_file_ff   <= MIN_FILE_RESET;
         max_aspect_ff <= MAX_ASPECT_RESET;
         min_height_ff <= MIN_SIDE_RESET;
         min_width_ff  <= MIN_SIDE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_FILE:   min_file_ff   <= csr_wdata[BYTES_W-1:0];
            CSR_MAX_ASPECT: max_aspect_ff <= csr_wdata[ASPECT_W-1:0];
            CSR_MIN_HEIGHT: min_height_ff <= csr_wdata[SIDE_W-1:0];
            CSR_MIN_WIDTH:  min_width_ff  <= csr_wdata[SIDE_W-1:0];
            default:        min_file_ff   <= min_file_ff;
         endcase
      end
   end

   // a last pixel closes the input until its result is loaded
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.last_pixel) |=> !req_ready)
      else $error("req_ready high right after a last pixel transfer");

   // rejected pictures carry no color or sides
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_PROCESSED) |->
      (rsp_data.mean_rgb == '0 && rsp_data.out_width == '0 && rsp_data.out_height == '0))
      else $error("rejected result with nonzero payload");

   // sums are cleared when a result is loaded
   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
      (red_sum_ff == '0 && green_sum_ff == '0 && blue_sum_ff == '0))
      else $error("channel sums not cleared with result load");

   // the divider never runs past the last channel
   a_div_chan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (chan_ff != 2'd3 && bit_ff <= BIT_W'(SUM_W-1)))
      else $error("divider sequencer out of range");

endmodule

// ===== bench/ismc_screen_checker.sv =====
// checker for the picture screening and mean color block: watches the csr, req and rsp
// channels, predicts each picture verdict and compares it with the block's transfers
// depends on ismc_pkg for payload types, verdict codes and register indexes
module ismc_screen_checker
   import ismc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    results_owed
);

   // screening limits as last written
   logic [BYTES_W-1:0]  min_file_limit = MIN_FILE_RESET;
   logic [ASPECT_W-1:0] aspect_limit   = MAX_ASPECT_RESET;
   logic [SIDE_W-1:0]   min_height_limit = MIN_SIDE_RESET;
   logic [SIDE_W-1:0]   min_width_limit  = MIN_SIDE_RESET;

   // running channel sums of the picture in progress
   logic [SUM_W-1:0] red_total   = '0;
   logic [SUM_W-1:0] green_total = '0;
   logic [SUM_W-1:0] blue_total  = '0;

   rsp_type verdict_q[$];
   rsp_type oldest_verdict;

   // saturating add of one level into a sum
   function automatic logic [SUM_W-1:0] sat_accumulate(logic [SUM_W-1:0] total,
                                                       logic [LEVEL_W-1:0] level);
      logic [SUM_W:0] wide;
      wide = {1'b0, total} + (SUM_W+1)'(level);
      return wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
   endfunction

   // truncating mean of one channel, zero for an empty picture, capped at full scale
   function automatic logic [LEVEL_W-1:0] channel_mean(logic [SUM_W-1:0] total,
                                                      logic [63:0] count);
      logic [63:0] quotient;
      if (count == 0)
         return '0;
      quotient = 64'(total) / count;
      return (quotient > 64'(8'hFF)) ? 8'hFF : quotient[LEVEL_W-1:0];
   endfunction

   // verdict for a picture whose last pixel is px, sums already include it
   function automatic rsp_type screen_picture(req_type px);
      logic [63:0] w;
      logic [63:0] h;
      logic [63:0] one_q8;
      rsp_type verdict;
      one_q8 = 64'(1) << FRAC_W;
      w = (px.image_width > MAX_SIDE_DEFAULT) ? 64'(MAX_SIDE_DEFAULT) : 64'(px.image_width);
      h = (px.image_height > MAX_SIDE_DEFAULT) ? 64'(MAX_SIDE_DEFAULT) : 64'(px.image_height);
      verdict = '0;
      if (px.file_bytes < min_file_limit) begin
         verdict.status = ST_FILE_SMALL;
      end else if (w * one_q8 > 64'(aspect_limit) * h ||
                   h * one_q8 > 64'(aspect_limit) * w) begin
         verdict.status = ST_ASPECT;
      end else if (h < 64'(min_height_limit) || w < 64'(min_width_limit)) begin
         verdict.status = ST_TOO_SMALL;
      end else begin
         verdict.status     = ST_PROCESSED;
         verdict.mean_rgb   = {channel_mean(red_total, w * h),
                               channel_mean(green_total, w * h),
                               channel_mean(blue_total, w * h)};
         verdict.out_width  = w[SIDE_W-1:0];
         verdict.out_height = h[SIDE_W-1:0];
      end
      return verdict;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         min_file_limit   = MIN_FILE_RESET;
         aspect_limit     = MAX_ASPECT_RESET;
         min_height_limit = MIN_SIDE_RESET;
         min_width_limit  = MIN_SIDE_RESET;
         red_total   = '0;
         green_total = '0;
         blue_total  = '0;
         verdict_q.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_MIN_FILE:   min_file_limit   = csr_wdata[BYTES_W-1:0];
               CSR_MAX_ASPECT: aspect_limit     = csr_wdata[ASPECT_W-1:0];
               CSR_MIN_HEIGHT: min_height_limit = csr_wdata[SIDE_W-1:0];
               CSR_MIN_WIDTH:  min_width_limit  = csr_wdata[SIDE_W-1:0];
               default: ;
            endcase
         end

         // result transfer against the oldest verdict
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               $error("unexpected result transfer: status %0d mean_rgb %06h",
                      rsp_data.status, rsp_data.mean_rgb);
               error_count++;
            end else begin
               oldest_verdict = verdict_q.pop_front();
               if (rsp_data.status !== oldest_verdict.status) begin
                  $error("status: expected %0d actual %0d",
                         oldest_verdict.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.mean_rgb !== oldest_verdict.mean_rgb) begin
                  $error("mean_rgb: expected %06h actual %06h",
                         oldest_verdict.mean_rgb, rsp_data.mean_rgb);
                  error_count++;
               end
               if (rsp_data.out_width !== oldest_verdict.out_width) begin
                  $error("out_width: expected %0d actual %0d",
                         oldest_verdict.out_width, rsp_data.out_width);
                  error_count++;
               end
               if (rsp_data.out_height !== oldest_verdict.out_height) begin
                  $error("out_height: expected %0d actual %0d",
                         oldest_verdict.out_height, rsp_data.out_height);
                  error_count++;
               end
            end
         end

         // pixel transfer: accumulate, screen on the last one
         if (req_valid && req_ready) begin
            red_total   = sat_accumulate(red_total, req_data.red_level);
            green_total = sat_accumulate(green_total, req_data.green_level);
            blue_total  = sat_accumulate(blue_total, req_data.blue_level);
            if (req_data.last_pixel) begin
               verdict_q.push_back(screen_picture(req_data));
               red_total   = '0;
               green_total = '0;
               blue_total  = '0;
            end
         end
      end
      results_owed = verdict_q.size();
   end

endmodule

// ===== bench/image_screen_mean_color_top_tb.sv =====
// testbench top for image_screen_mean_color_top: clock, reset, pixel and register
// stimulus, receiver stalls and the verdict; depends on ismc_pkg and ismc_screen_checker
module image_screen_mean_color_top_tb;
   import ismc_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_MIN_FILE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int error_count;
   int results_owed;

   // stimulus knobs
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          long_hold_left = 0;
   int          pixels_sent = 0;
   int unsigned file_floor = 0;

   image_screen_mean_color_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ismc_screen_checker screen_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .error_count  (error_count),
      .results_owed (results_owed)
   );

   always #5 clock = ~clock;

   // receiver: random stalls, or a long hold-off counted here
   always @(negedge clock) begin
      if (long_hold_left > 0) begin
         rsp_ready <= 1'b0;
         long_hold_left <= long_hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // run limit
   initial begin
      #(10 * 1_000_000);
      $display("DONE: errors detected");
      $finish;
   end

   // one register write; caller drops csr_valid after the last one
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic load_screen(input logic [BYTES_W-1:0] file_min,
                              input logic [ASPECT_W-1:0] aspect,
                              input logic [SIDE_W-1:0] height_min,
                              input logic [SIDE_W-1:0] width_min);
      write_reg(CSR_MIN_FILE, CSR_DATA_W'(file_min));
      write_reg(CSR_MAX_ASPECT, CSR_DATA_W'(aspect));
      write_reg(CSR_MIN_HEIGHT, CSR_DATA_W'(height_min));
      write_reg(CSR_MIN_WIDTH, CSR_DATA_W'(width_min));
      csr_valid <= 1'b0;
      file_floor = file_min;
   endtask

   // one pixel transfer with optional idle cycles ahead of it
   task automatic send_pixel(input req_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      pixels_sent++;
   endtask

   task automatic pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                        input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h,
                        input logic [BYTES_W-1:0] fbytes, input logic last);
      req_type px;
      px.red_level    = r;
      px.green_level  = g;
      px.blue_level   = b;
      px.image_width  = w;
      px.image_height = h;
      px.file_bytes   = fbytes;
      px.last_pixel   = last;
      send_pixel(px);
   endtask

   // stop sending, wait out every owed result and the block's latency
   task automatic settle();
      req_valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (130) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_level();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // a picture of npix pixels; earlier pixels sometimes carry stray sides and size
   task automatic stream_picture(input int w, input int h, input int unsigned fbytes,
                                 input int npix);
      logic last;
      for (int i = 0; i < npix; i++) begin
         last = (i == npix - 1);
         if (!last && $urandom_range(3) == 0)
            pixel(pick_level(), pick_level(), pick_level(), SIDE_W'($urandom_range(16383)),
                  SIDE_W'($urandom_range(16383)), $urandom, 1'b0);
         else
            pixel(pick_level(), pick_level(), pick_level(), SIDE_W'(w), SIDE_W'(h),
                  fbytes, last);
      end
   endtask

   task automatic random_picture();
      int w;
      int h;
      int npix;
      int roll;
      int unsigned fbytes;
      roll = $urandom_range(99);
      if (roll < 65) begin
         // ordinary small picture, one pixel per position
         w = $urandom_range(6, 1);
         h = $urandom_range(6, 1);
         npix = w * h;
      end else if (roll < 80) begin
         // side ratios around the aspect limit
         h = $urandom_range(4, 1);
         w = $urandom_range(4 * h, 1);
         if ($urandom_range(1)) begin
            npix = w;
            w = h;
            h = npix;
         end
         npix = $urandom_range(4, 1);
      end else if (roll < 90) begin
         // any side the field holds, zero and above the maximum included
         w = $urandom_range(16383);
         h = $urandom_range(16383);
         npix = $urandom_range(3, 1);
      end else begin
         // more pixels than the sides claim, so means can cap at full scale
         w = $urandom_range(2, 1);
         h = $urandom_range(2, 1);
         npix = w * h * $urandom_range(4, 2);
      end
      if ($urandom_range(9) == 0)
         fbytes = $urandom;
      else
         fbytes = $urandom_range(32'hFFFF_FFFF, file_floor);
      stream_picture(w, h, fbytes, npix);
   endtask

   task automatic run_phase(input int idle_pct, input int stall, input int item_count);
      int stop_at;
      send_idle_pct = idle_pct;
      stall_pct = stall;
      stop_at = pixels_sent + item_count;
      while (pixels_sent < stop_at) random_picture();
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset limits: extremes, zero sides, oversize sides, ratio edge
      pixel(8'hFF, 8'hFF, 8'hFF, 1, 1, 32'hFFFF_FFFF, 1'b1);
      pixel(8'h00, 8'h00, 8'h00, 1, 1, 32'h0000_0000, 1'b1);
      pixel(8'h80, 8'h40, 8'h20, 0, 0, 32'd500, 1'b1);
      pixel(8'h11, 8'h22, 8'h33, 0, 1, 32'd500, 1'b1);
      pixel(8'hFF, 8'h01, 8'hFE, 14'h3FFF, 14'h3FFF, 32'd500, 1'b1);
      pixel(8'd10, 8'd20, 8'd30, 2, 1, 32'd500, 1'b0);
      pixel(8'd11, 8'd21, 8'd31, 2, 1, 32'd500, 1'b1);
      pixel(8'd90, 8'd90, 8'd90, 3, 1, 32'd500, 1'b1);
      pixel(8'd90, 8'd90, 8'd90, 1, 3, 32'd500, 1'b1);
      pixel(8'd200, 8'd100, 8'd255, 1, 1, 32'd500, 1'b0);
      pixel(8'd200, 8'd100, 8'd255, 1, 1, 32'd500, 1'b0);
      pixel(8'd200, 8'd100, 8'd255, 1, 1, 32'd500, 1'b1);
      pixel(8'd7, 8'd8, 8'd9, 14'h2AAA, 14'h1555, 32'h5555_5555, 1'b0);
      pixel(8'd9, 8'd8, 8'd7, 2, 1, 32'd500, 1'b1);
      settle();

      // directed, raised limits: each rejection and their precedence
      load_screen(32'd1000, 16'd512, 14'd3, 14'd3);
      pixel(8'd50, 8'd60, 8'd70, 3, 3, 32'd0, 1'b1);
      pixel(8'd50, 8'd60, 8'd70, 2, 2, 32'd1000, 1'b1);
      pixel(8'd50, 8'd60, 8'd70, 8, 2, 32'd10, 1'b1);
      pixel(8'd50, 8'd60, 8'd70, 8, 2, 32'd2000, 1'b1);
      pixel(8'd50, 8'd60, 8'd70, 3, 3, 32'd4000, 1'b1);
      settle();

      // random phases across limit settings and idling patterns
      load_screen(32'd0, 16'd512, 14'd0, 14'd0);
      run_phase(0, 0, 140);
      settle();
      load_screen(32'd5000, 16'd768, 14'd2, 14'd1);
      run_phase(78, 0, 140);
      settle();
      load_screen(32'd0, 16'd256, 14'd0, 14'd0);
      run_phase(0, 78, 140);
      settle();
      load_screen(32'd0, 16'hFFFF, 14'd0, 14'd0);
      run_phase(14, 14, 140);
      settle();
      load_screen(32'hFFFF_FFFF, 16'd512, 14'd0, 14'd0);
      run_phase(0, 0, 60);
      settle();
      load_screen($urandom_range(2000), $urandom_range(1024, 256), $urandom_range(4),
                  $urandom_range(4));
      run_phase(78, 0, 140);
      settle();
      load_screen(32'd0, 16'd512, 14'd8192, 14'd8192);
      run_phase(0, 78, 80);
      settle();

      // receiver holds off while pixels keep coming, so the input backs up
      load_screen($urandom_range(2000), $urandom_range(1024, 256), $urandom_range(4),
                  $urandom_range(4));
      long_hold_left = 500;
      run_phase(0, 0, 70);
      settle();
      run_phase(14, 14, 70);
      settle();
      load_screen($urandom_range(2000), $urandom_range(1024, 256), $urandom_range(4),
                  $urandom_range(4));
      run_phase(0, 0, 140);
      settle();

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
